FILE: rtl/rpb_pkg.sv
`default_nettype none

package rpb_pkg;

	// Opcodes carried with each pixel request
	localparam logic [2:0] OP_MULTIPLY  = 3'd0;
	localparam logic [2:0] OP_SUBTRACT  = 3'd1;
	localparam logic [2:0] OP_SCREEN    = 3'd2;
	localparam logic [2:0] OP_OVERLAY   = 3'd3;
	localparam logic [2:0] OP_ADD_GREEN = 3'd4;
	localparam logic [2:0] OP_SCALE_RED = 3'd5;
	localparam logic [2:0] OP_GREY      = 3'd6;

	// Configuration register indexes
	localparam logic [1:0] REG_GREEN_OFFSET = 2'd0;
	localparam logic [1:0] REG_RED_GAIN     = 2'd1;
	localparam logic [1:0] REG_GREY_SOURCE  = 2'd2;

	// Grey source codes
	localparam logic [1:0] GREY_BLUE  = 2'd0;
	localparam logic [1:0] GREY_GREEN = 2'd1;
	localparam logic [1:0] GREY_RED   = 2'd2;

	// Register reset values
	localparam logic [7:0] GREEN_OFFSET_RST = 8'd200;
	localparam logic [3:0] RED_GAIN_RST     = 4'd4;
	localparam logic [1:0] GREY_SOURCE_RST  = GREY_RED;

	localparam int NUM_CHAN = 3;

	// Per-channel work after operand selection
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       dbl;
		logic       inv;
		logic       use_prod;
		logic [7:0] direct;
	} chan_s1_t;

	// Per-channel work after the multiply
	typedef struct packed {
		logic [16:0] prod;
		logic        inv;
		logic        use_prod;
		logic [7:0]  direct;
	} chan_s2_t;

endpackage

`default_nettype wire

FILE: rtl/rpb_ifs.sv
`default_nettype none

// Pixel request channel into the blend unit
interface rpb_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] a_blue;
	logic [7:0] a_green;
	logic [7:0] a_red;
	logic [7:0] b_blue;
	logic [7:0] b_green;
	logic [7:0] b_red;

	modport source (output valid, opcode, a_blue, a_green, a_red, b_blue, b_green, b_red,
		input ready);
	modport sink (input valid, opcode, a_blue, a_green, a_red, b_blue, b_green, b_red,
		output ready);
endinterface

// Result pixel channel out of the blend unit
interface rpb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;

	modport source (output valid, out_blue, out_green, out_red, input ready);
	modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

// Configuration write channel
interface rpb_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rgb_pixel_blend_unit.sv
`default_nettype none

// Per-pixel blend of two 8-bit BGR pixels (A on top, B below) under an opcode:
// multiply, subtract, screen, overlay, add green offset, scale red, grey extract.
// The unit is a three-stage pipeline that takes one pixel request per cycle unless
// stalled and returns results from the stage 3 register; stage 1 selects operands,
// stage 2 holds the 8x8 channel multiplies, stage 3 does the rounded divide by 255
// and drives the output register. Back pressure stalls each stage only when the
// stage after it is full, so bubbles are squeezed out and throughput stays at one
// pixel per cycle while the output is taken. Configuration writes are taken every
// cycle and should be made while no request is in flight.
module rgb_pixel_blend_unit (
	input  wire       clk,
	input  wire       arst_n,
	rpb_cfg_if.sink   cfg,
	rpb_in_if.sink    pix_in,
	rpb_out_if.source pix_out
);

	localparam int NC = rpb_pkg::NUM_CHAN;

	// Configuration registers
	logic [7:0] green_offset_q;
	logic [3:0] red_gain_q;
	logic [1:0] grey_source_q;

	// Pipeline valid bits and payload
	logic v_s1, v_s2, v_s3;
	rpb_pkg::chan_s1_t ch_s1 [NC];
	rpb_pkg::chan_s2_t ch_s2 [NC];
	logic [7:0] pix_s3 [NC];

	// Stage enables
	logic en1, en2, en3;

	// Stage 1 inputs
	logic [7:0] a [NC];
	logic [7:0] b [NC];
	rpb_pkg::chan_s1_t ch_d1 [NC];
	logic [8:0]  green_sum;
	logic [11:0] red_prod;
	logic [7:0]  green_sat;
	logic [7:0]  red_sat;
	logic [7:0]  grey_val;

	// Stage 3 inputs
	logic [7:0] pix_d3 [NC];

	// Advance a stage when it is empty or the next one moves
	assign en3 = !v_s3 || pix_out.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1;
	assign cfg.ready = 1'b1;

	// Write configuration registers, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_offset_q <= rpb_pkg::GREEN_OFFSET_RST;
			red_gain_q     <= rpb_pkg::RED_GAIN_RST;
			grey_source_q  <= rpb_pkg::GREY_SOURCE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rpb_pkg::REG_GREEN_OFFSET: green_offset_q <= cfg.data;
				rpb_pkg::REG_RED_GAIN:     red_gain_q     <= cfg.data[3:0];
				rpb_pkg::REG_GREY_SOURCE:  grey_source_q  <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	assign a[0] = pix_in.a_blue;
	assign a[1] = pix_in.a_green;
	assign a[2] = pix_in.a_red;
	assign b[0] = pix_in.b_blue;
	assign b[1] = pix_in.b_green;
	assign b[2] = pix_in.b_red;

	// Saturating green add, red gain and grey pick
	assign green_sum = {1'b0, pix_in.a_green} + {1'b0, green_offset_q};
	assign green_sat = green_sum[8] ? 8'hFF : green_sum[7:0];
	assign red_prod  = {4'd0, pix_in.a_red} * {8'd0, red_gain_q};
	assign red_sat   = (red_prod[11:8] != 4'd0) ? 8'hFF : red_prod[7:0];

	always_comb begin
		case (grey_source_q)
			rpb_pkg::GREY_RED:   grey_val = pix_in.a_red;
			rpb_pkg::GREY_GREEN: grey_val = pix_in.a_green;
			default:             grey_val = pix_in.a_blue;
		endcase
	end

	// Select multiplier operands or a direct result per channel
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			ch_d1[k] = '0;
			case (pix_in.opcode)
				rpb_pkg::OP_MULTIPLY: begin
					ch_d1[k].x        = a[k];
					ch_d1[k].y        = b[k];
					ch_d1[k].use_prod = 1'b1;
				end
				rpb_pkg::OP_SUBTRACT: begin
					ch_d1[k].direct = (b[k] >= a[k]) ? (b[k] - a[k]) : 8'd0;
				end
				rpb_pkg::OP_SCREEN: begin
					ch_d1[k].x        = ~a[k];
					ch_d1[k].y        = ~b[k];
					ch_d1[k].inv      = 1'b1;
					ch_d1[k].use_prod = 1'b1;
				end
				rpb_pkg::OP_OVERLAY: begin
					ch_d1[k].x        = b[k][7] ? ~a[k] : a[k];
					ch_d1[k].y        = b[k][7] ? ~b[k] : b[k];
					ch_d1[k].dbl      = 1'b1;
					ch_d1[k].inv      = b[k][7];
					ch_d1[k].use_prod = 1'b1;
				end
				rpb_pkg::OP_ADD_GREEN: begin
					ch_d1[k].direct = (k == 1) ? green_sat : a[k];
				end
				rpb_pkg::OP_SCALE_RED: begin
					ch_d1[k].direct = (k == 2) ? red_sat : ((k == 1) ? a[k] : 8'd0);
				end
				rpb_pkg::OP_GREY: begin
					ch_d1[k].direct = grey_val;
				end
				default: ;
			endcase
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage 1 register
	always_ff @(posedge clk) begin
		if (en1 && pix_in.valid) begin
			for (int k = 0; k < NC; k++) ch_s1[k] <= ch_d1[k];
		end
	end

	// Stage 2: multiply, doubled for overlay
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int k = 0; k < NC; k++) begin
				ch_s2[k].prod     <= ({9'd0, ch_s1[k].x} * {9'd0, ch_s1[k].y}) << ch_s1[k].dbl;
				ch_s2[k].inv      <= ch_s1[k].inv;
				ch_s2[k].use_prod <= ch_s1[k].use_prod;
				ch_s2[k].direct   <= ch_s1[k].direct;
			end
		end
	end

	// Stage 3: round(p/255) = floor((p+127)/255) by shift and correction
	always_comb begin
		logic [16:0] m;
		logic [8:0]  q0;
		logic [9:0]  r;
		logic [8:0]  q;
		for (int k = 0; k < NC; k++) begin
			m  = ch_s2[k].prod + 17'd127;
			q0 = m[16:8];
			r  = {2'd0, m[7:0]} + {1'b0, q0};
			if (r >= 10'd510)
				q = q0 + 9'd2;
			else if (r >= 10'd255)
				q = q0 + 9'd1;
			else
				q = q0;
			if (!ch_s2[k].use_prod)
				pix_d3[k] = ch_s2[k].direct;
			else if (ch_s2[k].inv)
				pix_d3[k] = 8'hFF - q[7:0];
			else
				pix_d3[k] = q[7:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int k = 0; k < NC; k++) pix_s3[k] <= pix_d3[k];
		end
	end

	assign pix_out.valid     = v_s3;
	assign pix_out.out_blue  = pix_s3[0];
	assign pix_out.out_green = pix_s3[1];
	assign pix_out.out_red   = pix_s3[2];

`ifndef ASSERT_OFF
	// An accepted request always lands in stage 1
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> v_s1)
		else $error("accepted request did not reach stage 1");

	// A full stage 1 only takes a request when it drains
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready && v_s1 |-> en2)
		else $error("stage 1 overwritten");

	// Stage 2 moving forward fills the output register
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> v_s3)
		else $error("stage 2 item lost");

	// A stalled result stays valid
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !pix_out.ready |=> v_s3)
		else $error("stalled result dropped");

	// Red gain write takes the low four data bits
	a_gain_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.index == rpb_pkg::REG_RED_GAIN |=> red_gain_q == $past(cfg.data[3:0]))
		else $error("red gain write lost");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_rgb_pixel_blend_unit.sv
`default_nettype none

module tb_rgb_pixel_blend_unit;

	// Codes the package leaves unnamed
	localparam logic [2:0] OP_UNUSED       = 3'd7;
	localparam logic [1:0] GREY_ALIAS_BLUE = 2'd3;
	localparam logic [1:0] REG_UNMAPPED    = 2'd3;

	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	localparam int PIPE_LATENCY  = 3;
	localparam int LONG_HOLD     = 64;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 300;
	localparam int NUM_PHASES    = 6;
	localparam int MAX_PRINTS    = 60;

	typedef logic [rpb_pkg::NUM_CHAN-1:0][7:0] pixel_t;

	typedef struct packed {
		logic [2:0] opcode;
		pixel_t     a;
		pixel_t     b;
	} pix_req_t;

	typedef struct packed {
		pix_req_t req;
		pixel_t   pix;
	} pending_t;

	typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// Mirror of the block's registers plus the pixels still owed by it
	class blend_scoreboard;
		logic [7:0] green_offset;
		logic [3:0] red_gain;
		logic [1:0] grey_source;
		pending_t   expected_pixels[$];
		int         err_count;

		function new();
			green_offset = rpb_pkg::GREEN_OFFSET_RST;
			red_gain     = rpb_pkg::RED_GAIN_RST;
			grey_source  = rpb_pkg::GREY_SOURCE_RST;
			err_count    = 0;
		endfunction

		function void mirror_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				rpb_pkg::REG_GREEN_OFFSET: green_offset = data;
				rpb_pkg::REG_RED_GAIN:     red_gain     = data[3:0];
				rpb_pkg::REG_GREY_SOURCE:  grey_source  = data[1:0];
				default: ;
			endcase
		endfunction

		// Round p/255 to nearest; ties cannot occur
		function logic [7:0] div255(int unsigned p);
			return 8'((2 * p + 255) / 510);
		endfunction

		function logic [7:0] blend_chan(logic [2:0] op, logic [7:0] a, logic [7:0] b);
			int unsigned ua;
			int unsigned ub;
			ua = a;
			ub = b;
			case (op)
				rpb_pkg::OP_MULTIPLY: return div255(ua * ub);
				rpb_pkg::OP_SUBTRACT: return (ub >= ua) ? 8'(ub - ua) : 8'd0;
				rpb_pkg::OP_SCREEN:   return 8'(255 - div255((255 - ua) * (255 - ub)));
				rpb_pkg::OP_OVERLAY: begin
					if (ub <= 127)
						return div255(2 * ua * ub);
					return 8'(255 - div255(2 * (255 - ua) * (255 - ub)));
				end
				default: return 8'd0;
			endcase
		endfunction

		function pixel_t blend_pixel(pix_req_t r);
			pixel_t      res;
			int unsigned t;
			res = '0;
			case (r.opcode)
				rpb_pkg::OP_MULTIPLY, rpb_pkg::OP_SUBTRACT,
				rpb_pkg::OP_SCREEN, rpb_pkg::OP_OVERLAY: begin
					for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++)
						res[ch] = blend_chan(r.opcode, r.a[ch], r.b[ch]);
				end
				rpb_pkg::OP_ADD_GREEN: begin
					t = r.a[CH_GREEN] + green_offset;
					res[CH_BLUE]  = r.a[CH_BLUE];
					res[CH_GREEN] = (t > 255) ? 8'd255 : 8'(t);
					res[CH_RED]   = r.a[CH_RED];
				end
				rpb_pkg::OP_SCALE_RED: begin
					t = r.a[CH_RED] * red_gain;
					res[CH_BLUE]  = 8'd0;
					res[CH_GREEN] = r.a[CH_GREEN];
					res[CH_RED]   = (t > 255) ? 8'd255 : 8'(t);
				end
				rpb_pkg::OP_GREY: begin
					// grey source 3 falls back to blue
					case (grey_source)
						rpb_pkg::GREY_RED:   t = r.a[CH_RED];
						rpb_pkg::GREY_GREEN: t = r.a[CH_GREEN];
						default:             t = r.a[CH_BLUE];
					endcase
					for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++)
						res[ch] = 8'(t);
				end
				default: res = '0;
			endcase
			return res;
		endfunction

		function void note_request(pix_req_t r);
			pending_t p;
			p.req = r;
			p.pix = blend_pixel(r);
			expected_pixels.push_back(p);
		endfunction

		task report_mismatch(string msg);
			if (err_count < MAX_PRINTS)
				$display("MISMATCH: %s", msg);
			err_count++;
		endtask

		task check_pixel(pixel_t got);
			pending_t p;
			string    chan_names[rpb_pkg::NUM_CHAN];
			chan_names = '{"out_blue", "out_green", "out_red"};
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %h with no request outstanding", got));
				return;
			end
			p = expected_pixels.pop_front();
			for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
				if (got[ch] !== p.pix[ch])
					report_mismatch($sformatf("%s got %0d expected %0d (op %0d a %h b %h)",
						chan_names[ch], got[ch], p.pix[ch], p.req.opcode, p.req.a, p.req.b));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic long_hold_req;

	blend_scoreboard sb;

	rpb_cfg_if cfg_if ();
	rpb_in_if  in_if ();
	rpb_out_if out_if ();

	rgb_pixel_blend_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.pix_in  (in_if),
		.pix_out (out_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Track register writes and requests as the block accepts them
	always @(posedge clk) begin
		if (arst_n && cfg_if.valid && cfg_if.ready)
			sb.mirror_reg(cfg_if.index, cfg_if.data);
	end

	always @(posedge clk) begin
		pix_req_t r;
		if (arst_n && in_if.valid && in_if.ready) begin
			r.opcode          = in_if.opcode;
			r.a[CH_BLUE]      = in_if.a_blue;
			r.a[CH_GREEN]     = in_if.a_green;
			r.a[CH_RED]       = in_if.a_red;
			r.b[CH_BLUE]      = in_if.b_blue;
			r.b[CH_GREEN]     = in_if.b_green;
			r.b[CH_RED]       = in_if.b_red;
			sb.note_request(r);
		end
	end

	// Compare each result taken from the block
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && out_if.valid && out_if.ready) begin
			got[CH_BLUE]  = out_if.out_blue;
			got[CH_GREEN] = out_if.out_green;
			got[CH_RED]   = out_if.out_red;
			sb.check_pixel(got);
		end
	end

	// Result side back pressure: changing patterns, plus a long hold on request
	initial begin : rx_side
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		mode      = RX_ALWAYS;
		mode_left = 0;
		tick      = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (mode)
					RX_ALWAYS:   out_if.ready <= 1'b1;
					RX_MOSTLY:   out_if.ready <= ($urandom_range(0, 9) < 7);
					RX_SPARSE:   out_if.ready <= ($urandom_range(0, 9) < 3);
					default:     out_if.ready <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic pix_req_t mk_req(logic [2:0] op,
		logic [7:0] ab, logic [7:0] ag, logic [7:0] ar,
		logic [7:0] bb, logic [7:0] bg, logic [7:0] br);
		pix_req_t r;
		r.opcode      = op;
		r.a[CH_BLUE]  = ab;
		r.a[CH_GREEN] = ag;
		r.a[CH_RED]   = ar;
		r.b[CH_BLUE]  = bb;
		r.b[CH_GREEN] = bg;
		r.b[CH_RED]   = br;
		return r;
	endfunction

	// Favor the corners of the channel range, overlay threshold included
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 11))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd127;
			3:       return 8'd128;
			4:       return 8'($urandom_range(0, 3));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_req_t rand_request();
		int       pick;
		pix_req_t r;
		pick     = $urandom_range(0, 28);
		r.opcode = (pick == 28) ? OP_UNUSED : 3'(pick % 7);
		for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
			r.a[ch] = rand_chan();
			r.b[ch] = rand_chan();
		end
		return r;
	endfunction

	// Offer one request and hold it until accepted
	task automatic push_pixel(input pix_req_t r);
		in_if.valid   <= 1'b1;
		in_if.opcode  <= r.opcode;
		in_if.a_blue  <= r.a[CH_BLUE];
		in_if.a_green <= r.a[CH_GREEN];
		in_if.a_red   <= r.a[CH_RED];
		in_if.b_blue  <= r.b[CH_BLUE];
		in_if.b_green <= r.b[CH_GREEN];
		in_if.b_red   <= r.b[CH_RED];
		do @(posedge clk); while (!in_if.ready);
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every owed pixel has come back
	task automatic drain_results();
		int waited;
		waited = 0;
		in_if.valid <= 1'b0;
		while (sb.expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Random requests in bursts separated by random gaps, or back to back with no_gaps
	task automatic send_random(input int count, input bit no_gaps);
		int burst_left;
		int gap;
		int i;
		burst_left = 0;
		for (i = 0; i < count; i++) begin
			if (!no_gaps && burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			push_pixel(rand_request());
			if (burst_left > 0)
				burst_left--;
		end
	endtask

	// Pick a register setting, often at the extremes, with junk in unused bits
	task automatic randomize_regs();
		logic [7:0] green;
		logic [3:0] gain;
		case ($urandom_range(0, 2))
			0:       green = 8'd0;
			1:       green = 8'd255;
			default: green = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 2))
			0:       gain = 4'd0;
			1:       gain = 4'd15;
			default: gain = 4'($urandom_range(0, 15));
		endcase
		program_reg(rpb_pkg::REG_GREEN_OFFSET, green);
		program_reg(rpb_pkg::REG_RED_GAIN, {4'($urandom_range(0, 15)), gain});
		program_reg(rpb_pkg::REG_GREY_SOURCE, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 1) == 1)
			program_reg(REG_UNMAPPED, 8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		int phase;
		sb             = new();
		long_hold_req  = 1'b0;
		arst_n         = 1'b0;
		cfg_if.valid   = 1'b0;
		cfg_if.index   = '0;
		cfg_if.data    = '0;
		in_if.valid    = 1'b0;
		in_if.opcode   = '0;
		in_if.a_blue   = '0;
		in_if.a_green  = '0;
		in_if.a_red    = '0;
		in_if.b_blue   = '0;
		in_if.b_green  = '0;
		in_if.b_red    = '0;
		out_if.ready   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: offset 200, gain 4, grey from red
		push_pixel(mk_req(rpb_pkg::OP_MULTIPLY, 255, 255, 255, 255, 0, 128));
		push_pixel(mk_req(rpb_pkg::OP_MULTIPLY, 1, 128, 37, 1, 127, 200));
		push_pixel(mk_req(rpb_pkg::OP_SUBTRACT, 10, 200, 0, 5, 200, 255));
		push_pixel(mk_req(rpb_pkg::OP_SUBTRACT, 255, 0, 1, 0, 255, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCREEN, 0, 255, 100, 0, 0, 200));
		push_pixel(mk_req(rpb_pkg::OP_SCREEN, 255, 1, 254, 255, 254, 1));
		push_pixel(mk_req(rpb_pkg::OP_OVERLAY, 200, 200, 0, 127, 128, 0));
		push_pixel(mk_req(rpb_pkg::OP_OVERLAY, 255, 0, 255, 255, 127, 128));
		push_pixel(mk_req(rpb_pkg::OP_OVERLAY, 0, 255, 60, 128, 255, 127));
		push_pixel(mk_req(rpb_pkg::OP_ADD_GREEN, 9, 0, 7, 255, 255, 255));
		push_pixel(mk_req(rpb_pkg::OP_ADD_GREEN, 1, 56, 2, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_ADD_GREEN, 255, 255, 255, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCALE_RED, 77, 88, 63, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCALE_RED, 255, 255, 64, 1, 1, 1));
		push_pixel(mk_req(rpb_pkg::OP_GREY, 10, 20, 30, 40, 50, 60));
		push_pixel(mk_req(OP_UNUSED, 255, 255, 255, 255, 255, 255));
		drain_results();

		// Maximum offset and gain, grey from blue
		program_reg(rpb_pkg::REG_GREEN_OFFSET, 8'd255);
		program_reg(rpb_pkg::REG_RED_GAIN, 8'h0F);
		program_reg(rpb_pkg::REG_GREY_SOURCE, {6'd0, rpb_pkg::GREY_BLUE});
		push_pixel(mk_req(rpb_pkg::OP_ADD_GREEN, 3, 0, 4, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCALE_RED, 9, 8, 17, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCALE_RED, 9, 8, 18, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_GREY, 10, 20, 30, 0, 0, 0));
		drain_results();

		// Zero offset and gain; grey code 3; upper data bits must be dropped
		program_reg(rpb_pkg::REG_GREEN_OFFSET, 8'd0);
		program_reg(rpb_pkg::REG_RED_GAIN, 8'hF0);
		program_reg(rpb_pkg::REG_GREY_SOURCE, {6'h3F, GREY_ALIAS_BLUE});
		program_reg(REG_UNMAPPED, 8'h5A);
		push_pixel(mk_req(rpb_pkg::OP_ADD_GREEN, 0, 255, 0, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_SCALE_RED, 255, 255, 255, 0, 0, 0));
		push_pixel(mk_req(rpb_pkg::OP_GREY, 11, 22, 33, 0, 0, 0));
		drain_results();

		program_reg(rpb_pkg::REG_GREY_SOURCE, {6'd0, rpb_pkg::GREY_GREEN});
		push_pixel(mk_req(rpb_pkg::OP_GREY, 11, 22, 33, 0, 0, 0));
		drain_results();

		// Random phases, each under a fresh register setting
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			randomize_regs();
			if (phase == 1) begin
				// Hold the result side off while requests keep coming
				long_hold_req = 1'b1;
				send_random(40, 1'b1);
				send_random(PHASE_ITEMS - 40, 1'b0);
			end else if (phase == 3) begin
				send_random(PHASE_ITEMS / 2, 1'b0);
				drain_results();
				send_random(PHASE_ITEMS / 2, 1'b0);
			end else begin
				send_random(PHASE_ITEMS, phase == 4);
			end
			drain_results();
		end

		if (sb.expected_pixels.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.expected_pixels.size()));
		if (sb.err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/rpb_pkg.sv
rtl/rpb_ifs.sv
rtl/rgb_pixel_blend_unit.sv
dv/tb_rgb_pixel_blend_unit.sv
